@@ hw/rtl/drf_pkg.sv @@
// ============================================================================
// drf_pkg - shared types and constants of the dither restore filter
// Field positions, widths, register map and the per-lane vote record.
// ============================================================================
package drf_pkg;

	localparam int CENTER_W       = 8;
	localparam int WORD_W         = 32;
	localparam int FIELD_W        = 5;
	localparam int NEIGHBOR_COUNT = 8;
	localparam int OUT_W          = 10;
	// sum of eight votes in -8..8
	localparam int SUM_W          = 5;

	// 5-bit field positions (lowest bit) in the two neighbor layouts
	localparam int NARROW_RED_LSB   = 11;
	localparam int NARROW_GREEN_LSB = 6;
	localparam int NARROW_BLUE_LSB  = 1;
	localparam int WIDE_RED_LSB     = 27;
	localparam int WIDE_GREEN_LSB   = 19;
	localparam int WIDE_BLUE_LSB    = 11;

	localparam int IN_TDATA_W  = 3 * CENTER_W + NEIGHBOR_COUNT * WORD_W;
	localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	// register index, taken from the word address bit
	localparam logic REG_WIDE_FORMAT = 1'b0;

	typedef logic signed [1:0] vote_t;

	typedef struct packed {
		vote_t red;
		vote_t green;
		vote_t blue;
	} lane_votes_t;

	typedef struct packed {
		logic [FIELD_W-1:0] red;
		logic [FIELD_W-1:0] green;
		logic [FIELD_W-1:0] blue;
	} center_top_t;

endpackage

@@ hw/rtl/drf_lane.sv @@
// ============================================================================
// drf_lane - vote of one neighbor word
// Extract the three 5-bit fields and compare each with the center's top bits.
// ============================================================================
module drf_lane (
	input  logic                          wide_format,
	input  drf_pkg::center_top_t          center_top,
	input  logic [drf_pkg::WORD_W-1:0]    word,
	output drf_pkg::lane_votes_t          votes
);

	logic [drf_pkg::FIELD_W-1:0] red_f;
	logic [drf_pkg::FIELD_W-1:0] green_f;
	logic [drf_pkg::FIELD_W-1:0] blue_f;

	function automatic drf_pkg::vote_t cast_vote(
		input logic [drf_pkg::FIELD_W-1:0] c,
		input logic [drf_pkg::FIELD_W-1:0] n
	);
		drf_pkg::vote_t v;
		if (c < n) begin
			v = 2'sd1;
		end else if (c > n) begin
			v = -2'sd1;
		end else begin
			v = 2'sd0;
		end
		return v;
	endfunction

	// narrow layout only touches bits 15:1, so the upper half drops out by itself
	always_comb begin
		if (wide_format) begin
			red_f   = word[drf_pkg::WIDE_RED_LSB   +: drf_pkg::FIELD_W];
			green_f = word[drf_pkg::WIDE_GREEN_LSB +: drf_pkg::FIELD_W];
			blue_f  = word[drf_pkg::WIDE_BLUE_LSB  +: drf_pkg::FIELD_W];
		end else begin
			red_f   = word[drf_pkg::NARROW_RED_LSB   +: drf_pkg::FIELD_W];
			green_f = word[drf_pkg::NARROW_GREEN_LSB +: drf_pkg::FIELD_W];
			blue_f  = word[drf_pkg::NARROW_BLUE_LSB  +: drf_pkg::FIELD_W];
		end
	end

	assign votes.red   = cast_vote(center_top.red,   red_f);
	assign votes.green = cast_vote(center_top.green, green_f);
	assign votes.blue  = cast_vote(center_top.blue,  blue_f);

endmodule

@@ hw/rtl/drf_merge.sv @@
// ============================================================================
// drf_merge - combine lane votes
// Sum the eight votes per channel and add them to the full center value.
// ============================================================================
module drf_merge (
	input  drf_pkg::lane_votes_t            votes [drf_pkg::NEIGHBOR_COUNT],
	input  logic [drf_pkg::CENTER_W-1:0]    center_red,
	input  logic [drf_pkg::CENTER_W-1:0]    center_green,
	input  logic [drf_pkg::CENTER_W-1:0]    center_blue,
	output logic signed [drf_pkg::OUT_W-1:0] restored_red,
	output logic signed [drf_pkg::OUT_W-1:0] restored_green,
	output logic signed [drf_pkg::OUT_W-1:0] restored_blue
);

	logic signed [drf_pkg::SUM_W-1:0] sum_red;
	logic signed [drf_pkg::SUM_W-1:0] sum_green;
	logic signed [drf_pkg::SUM_W-1:0] sum_blue;

	always_comb begin
		sum_red   = '0;
		sum_green = '0;
		sum_blue  = '0;
		for (int i = 0; i < drf_pkg::NEIGHBOR_COUNT; i++) begin
			sum_red   = sum_red   + drf_pkg::SUM_W'(votes[i].red);
			sum_green = sum_green + drf_pkg::SUM_W'(votes[i].green);
			sum_blue  = sum_blue  + drf_pkg::SUM_W'(votes[i].blue);
		end
	end

	// zero-extend the center, sign-extend the sum
	assign restored_red   = $signed(drf_pkg::OUT_W'(center_red))
		+ drf_pkg::OUT_W'(sum_red);
	assign restored_green = $signed(drf_pkg::OUT_W'(center_green))
		+ drf_pkg::OUT_W'(sum_green);
	assign restored_blue  = $signed(drf_pkg::OUT_W'(center_blue))
		+ drf_pkg::OUT_W'(sum_blue);

endmodule

@@ hw/rtl/dither_restore_filter_unit.sv @@
// ============================================================================
// dither_restore_filter_unit - 3x3 dither restore vote filter
// Per channel, add one vote per neighbor (+1 above, -1 below the center's
// top five bits) to the 8-bit center value. Results are not clamped.
// ============================================================================
// Usage:
//   Input stream (s_*): one word per pixel carries the three center channels
//   and the eight raw neighbor words fetched by the caller (zero for a fetch
//   outside memory). Output stream (m_*): one word per input word, the three
//   restored channels as 10-bit two's complement values in -8..263.
//   APB port: register 0 (address 0), bit 0 selects the neighbor layout:
//   0 = 16-bit words (fields 15:11, 10:6, 5:1), 1 = 32-bit words (31:27,
//   23:19, 15:11). Write it only while the stream is idle.
//   Pipeline: two register stages; an accepted pixel enters stage 1, then the
//   output register that drives m_tvalid. Throughput: one pixel per cycle
//   while m_tready stays high; eight lanes compare all neighbors at once in
//   stage 1, the merge adder tree in stage 2 fills the output register.
//   Stall: when the receiver holds m_tready low the output register holds its
//   word and stage 1 still takes one more pixel; only with both full does
//   s_tready drop.
//   Reset: clears the pipeline valids and the layout bit (16-bit layout).
// ============================================================================
module dither_restore_filter_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [drf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [drf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [drf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// center_red, center_green, center_blue, upper_left_word, upper_word,
	// upper_right_word, left_word, right_word, lower_left_word, lower_word,
	// lower_right_word
	input  logic [drf_pkg::IN_TDATA_W-1:0]     s_tdata,
	// output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// restored_red, restored_green, restored_blue, 2 zero bits
	output logic [drf_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int CW = drf_pkg::CENTER_W;
	localparam int NC = drf_pkg::NEIGHBOR_COUNT;
	localparam int OW = drf_pkg::OUT_W;

	logic wide_format_q;

	logic cfg_write;
	logic adv_s1;
	logic adv_s2;

	logic valid_s1;
	logic valid_s2;

	logic [CW-1:0] in_red;
	logic [CW-1:0] in_green;
	logic [CW-1:0] in_blue;
	drf_pkg::center_top_t center_top;
	drf_pkg::lane_votes_t lane_votes [NC];

	drf_pkg::lane_votes_t votes_s1 [NC];
	logic [CW-1:0]        red_s1;
	logic [CW-1:0]        green_s1;
	logic [CW-1:0]        blue_s1;

	logic signed [OW-1:0] sum_red;
	logic signed [OW-1:0] sum_green;
	logic signed [OW-1:0] sum_blue;

	logic [drf_pkg::OUT_TDATA_W-1:0] tdata_s2;

	// ---------------- configuration ----------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_format_q <= 1'b0;
		end else if (cfg_write && paddr[2] == drf_pkg::REG_WIDE_FORMAT) begin
			wide_format_q <= pwdata[0];
		end
	end

	// read back the layout bit; other addresses read zero
	always_comb begin
		prdata = '0;
		if (paddr[2] == drf_pkg::REG_WIDE_FORMAT) begin
			prdata[0] = wide_format_q;
		end
	end

	// ---------------- flow control ----------------
	// stage 2 is the output register; stage 1 advances when it is empty or stage 2 frees up
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;
	assign m_tvalid = valid_s2;
	assign m_tdata  = tdata_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// ---------------- stage 1: neighbor lanes ----------------
	assign in_red   = s_tdata[0*CW +: CW];
	assign in_green = s_tdata[1*CW +: CW];
	assign in_blue  = s_tdata[2*CW +: CW];

	// compare against the top five bits of each center channel
	assign center_top.red   = in_red[CW-1 -: drf_pkg::FIELD_W];
	assign center_top.green = in_green[CW-1 -: drf_pkg::FIELD_W];
	assign center_top.blue  = in_blue[CW-1 -: drf_pkg::FIELD_W];

	for (genvar g = 0; g < NC; g++) begin : g_lane
		drf_lane u_lane (
			.wide_format (wide_format_q),
			.center_top  (center_top),
			.word        (s_tdata[3*CW + g*drf_pkg::WORD_W +: drf_pkg::WORD_W]),
			.votes       (lane_votes[g])
		);
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			votes_s1 <= lane_votes;
			red_s1   <= in_red;
			green_s1 <= in_green;
			blue_s1  <= in_blue;
		end
	end

	// ---------------- stage 2: merge ----------------
	drf_merge u_merge (
		.votes          (votes_s1),
		.center_red     (red_s1),
		.center_green   (green_s1),
		.center_blue    (blue_s1),
		.restored_red   (sum_red),
		.restored_green (sum_green),
		.restored_blue  (sum_blue)
	);

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			tdata_s2 <= drf_pkg::OUT_TDATA_W'({sum_blue, sum_green, sum_red});
		end
	end

	// ---------------- assertions ----------------
	// input only stalls when both stages hold words
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input stalled with room in the pipeline");

	// an accepted word lands in stage 1
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted word lost before stage 1");

	// a stage 1 word moves into the output register when it is free
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("stage 1 word lost before output");

	// restored red stays in -8..263
	a_red_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ($signed(tdata_s2[OW-1:0]) >= -10'sd8
			&& $signed(tdata_s2[OW-1:0]) <= 10'sd263))
		else $error("restored red out of range");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top - self-checking bench for dither_restore_filter_unit
// Streams center pixels with their eight neighbor words through the filter,
// predicts each restored word, and compares every channel as it comes out.
// Covers both neighbor layouts, bits that the filter must ignore, an unmapped
// register write, random idles and stalls on both sides, and a full drain.
// ============================================================================
module tb_top;

	localparam int CENTER_W       = drf_pkg::CENTER_W;
	localparam int WORD_W         = drf_pkg::WORD_W;
	localparam int FIELD_W        = drf_pkg::FIELD_W;
	localparam int NEIGHBOR_COUNT = drf_pkg::NEIGHBOR_COUNT;
	localparam int OUT_W          = drf_pkg::OUT_W;
	localparam int IN_TDATA_W     = drf_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W    = drf_pkg::OUT_TDATA_W;
	localparam int APB_DATA_W     = drf_pkg::APB_DATA_W;
	localparam int APB_ADDR_W     = drf_pkg::APB_ADDR_W;

	localparam int CYCLE_LIMIT  = 200000;
	// a little over the pipeline depth
	localparam int DRAIN_SLACK  = 4;
	localparam int REG_UNMAPPED = 1;
	localparam int PAD_W        = OUT_TDATA_W - 3 * OUT_W;

	// s_tdata layout: the first channel sits in the lowest bits
	typedef struct packed {
		logic [NEIGHBOR_COUNT-1:0][WORD_W-1:0] nbr;
		logic [CENTER_W-1:0]                   blue;
		logic [CENTER_W-1:0]                   green;
		logic [CENTER_W-1:0]                   red;
	} pixel_t;

	// m_tdata layout
	typedef struct packed {
		logic [PAD_W-1:0] pad;
		logic [OUT_W-1:0] blue;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] red;
	} restored_t;

	// Predicts the restored word of each accepted pixel and checks the
	// output stream against those predictions in order.
	class restore_checker;
		bit          wide_format;
		restored_t   expected_q[$];
		int unsigned mismatches;
		int unsigned pixels_noted;
		int unsigned words_checked;

		function logic [OUT_W-1:0] vote_channel(logic [CENTER_W-1:0] center,
				logic [NEIGHBOR_COUNT-1:0][WORD_W-1:0] nbr, int lsb);
			int acc;
			logic [WORD_W-1:0] w;
			logic [FIELD_W-1:0] f;
			acc = int'(center);
			for (int i = 0; i < NEIGHBOR_COUNT; i++) begin
				w = nbr[i];
				// narrow words live in the low half only
				if (!wide_format)
					w[WORD_W-1:16] = '0;
				f = w[lsb +: FIELD_W];
				if (f > center[CENTER_W-1:CENTER_W-FIELD_W])
					acc++;
				else if (f < center[CENTER_W-1:CENTER_W-FIELD_W])
					acc--;
			end
			return acc[OUT_W-1:0];
		endfunction

		function restored_t restore_pixel(pixel_t px);
			restored_t r;
			r.pad = '0;
			if (wide_format) begin
				r.red   = vote_channel(px.red, px.nbr, drf_pkg::WIDE_RED_LSB);
				r.green = vote_channel(px.green, px.nbr, drf_pkg::WIDE_GREEN_LSB);
				r.blue  = vote_channel(px.blue, px.nbr, drf_pkg::WIDE_BLUE_LSB);
			end else begin
				r.red   = vote_channel(px.red, px.nbr, drf_pkg::NARROW_RED_LSB);
				r.green = vote_channel(px.green, px.nbr, drf_pkg::NARROW_GREEN_LSB);
				r.blue  = vote_channel(px.blue, px.nbr, drf_pkg::NARROW_BLUE_LSB);
			end
			return r;
		endfunction

		function void note_write(int index, logic [APB_DATA_W-1:0] value);
			if (index == drf_pkg::REG_WIDE_FORMAT)
				wide_format = value[0];
		endfunction

		function void note_pixel(pixel_t px);
			expected_q.push_back(restore_pixel(px));
			pixels_noted++;
		endfunction

		task flag_mismatch(string msg);
			$display("[%0t] MISMATCH %s", $time, msg);
			mismatches++;
		endtask

		task check_restored(restored_t got);
			restored_t want;
			if (expected_q.size() == 0) begin
				flag_mismatch($sformatf("restored word %h with no pixel pending", got));
				return;
			end
			want = expected_q.pop_front();
			words_checked++;
			if (got.red !== want.red)
				flag_mismatch($sformatf("red got %0d want %0d",
					$signed(got.red), $signed(want.red)));
			if (got.green !== want.green)
				flag_mismatch($sformatf("green got %0d want %0d",
					$signed(got.green), $signed(want.green)));
			if (got.blue !== want.blue)
				flag_mismatch($sformatf("blue got %0d want %0d",
					$signed(got.blue), $signed(want.blue)));
			if (got.pad !== '0)
				flag_mismatch($sformatf("pad bits got %b, want zero", got.pad));
		endtask
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_W-1:0]     paddr;
	logic [APB_DATA_W-1:0]     pwdata;
	logic [APB_DATA_W-1:0]     prdata;
	logic                      pready;
	logic                      s_tvalid;
	logic                      s_tready;
	// center_red, center_green, center_blue, then the eight neighbor words
	// from upper_left_word up to lower_right_word
	logic [IN_TDATA_W-1:0]     s_tdata;
	logic                      m_tvalid;
	logic                      m_tready;
	// restored_red, restored_green, restored_blue, 2 zero bits
	logic [OUT_TDATA_W-1:0]    m_tdata;

	restore_checker model = new();
	// percent of cycles in which each side idles; zero for a clean stretch
	int          idle_pct;
	int unsigned cycles;
	int unsigned layout_writes;

	dither_restore_filter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: end the run if the filter stops moving words.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[%0t] timeout after %0d cycles", $time, cycles);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Receiver: check every accepted word, then roll the stall for the next
	// edge. One nonblocking write of m_tready per edge.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				model.check_restored(restored_t'(m_tdata));
			m_tready <= arst_n && ($urandom_range(99) >= idle_pct);
		end
	end

	// Put the three 5-bit fields of one neighbor word in the current layout.
	function automatic logic [WORD_W-1:0] place_fields(logic [WORD_W-1:0] w, bit wide,
			logic [FIELD_W-1:0] r, logic [FIELD_W-1:0] g, logic [FIELD_W-1:0] b);
		if (wide) begin
			w[drf_pkg::WIDE_RED_LSB +: FIELD_W]   = r;
			w[drf_pkg::WIDE_GREEN_LSB +: FIELD_W] = g;
			w[drf_pkg::WIDE_BLUE_LSB +: FIELD_W]  = b;
		end else begin
			w[drf_pkg::NARROW_RED_LSB +: FIELD_W]   = r;
			w[drf_pkg::NARROW_GREEN_LSB +: FIELD_W] = g;
			w[drf_pkg::NARROW_BLUE_LSB +: FIELD_W]  = b;
		end
		return w;
	endfunction

	function automatic pixel_t fill_pixel(logic [CENTER_W-1:0] r, logic [CENTER_W-1:0] g,
			logic [CENTER_W-1:0] b, logic [WORD_W-1:0] w);
		pixel_t px;
		px.red   = r;
		px.green = g;
		px.blue  = b;
		for (int i = 0; i < NEIGHBOR_COUNT; i++)
			px.nbr[i] = w;
		return px;
	endfunction

	// Bias centers toward the ends of the range.
	function automatic logic [CENTER_W-1:0] pick_center();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return CENTER_W'($urandom);
		endcase
	endfunction

	// Neighbor field one step around the center's top bits, so equal votes
	// and both directions show up often.
	function automatic logic [FIELD_W-1:0] near_field(logic [CENTER_W-1:0] center);
		int v;
		v = int'(center[CENTER_W-1:CENTER_W-FIELD_W]) + int'($urandom_range(2)) - 1;
		if (v < 0)
			v = 0;
		if (v > 31)
			v = 31;
		return v[FIELD_W-1:0];
	endfunction

	function automatic pixel_t random_pixel(bit wide);
		pixel_t px;
		int kind;
		px.red   = pick_center();
		px.green = pick_center();
		px.blue  = pick_center();
		kind = $urandom_range(9);
		for (int i = 0; i < NEIGHBOR_COUNT; i++) begin
			px.nbr[i] = $urandom;
			if (kind <= 5)
				px.nbr[i] = place_fields(px.nbr[i], wide, near_field(px.red),
					near_field(px.green), near_field(px.blue));
			else if (kind == 6)
				px.nbr[i] = place_fields(px.nbr[i], wide, '1, '1, '1);
			else if (kind == 7)
				px.nbr[i] = place_fields(px.nbr[i], wide, '0, '0, '0);
		end
		return px;
	endfunction

	// Offer one pixel and hold it until the filter takes it. s_tvalid stays
	// high on return so back-to-back words need no extra write.
	task automatic push_pixel(pixel_t px);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		model.note_pixel(px);
	endtask

	// Drop the stream and hold until every predicted word has been checked.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (model.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK)
			@(posedge clk);
	endtask

	task automatic write_reg(int index, logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(4 * index);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		model.note_write(index, value);
		if (index == drf_pkg::REG_WIDE_FORMAT)
			layout_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Read the layout register back; only bit 0 carries state.
	task automatic read_format_reg();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= APB_ADDR_W'(4 * drf_pkg::REG_WIDE_FORMAT);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[0] !== model.wide_format)
			model.flag_mismatch($sformatf("layout register read %b want %b",
				prdata[0], model.wide_format));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Extremes of the vote sum, equal fields, and bits that must be ignored.
	task automatic send_directed(bit wide);
		pixel_t px;
		// every neighbor above: +8 from zero, and the largest result 255
		push_pixel(fill_pixel(8'd0, 8'd0, 8'd0, '1));
		push_pixel(fill_pixel(8'd247, 8'd247, 8'd247, '1));
		// every neighbor below: 8 - 8 down to zero, and 255 - 8
		push_pixel(fill_pixel(8'd8, 8'd8, 8'd8, '0));
		push_pixel(fill_pixel(8'd255, 8'd255, 8'd255, '0));
		// fields equal to the center's top bits leave the center as it is
		push_pixel(fill_pixel(8'h80, 8'h40, 8'h20, place_fields('0, wide, 5'd16, 5'd8, 5'd4)));
		// upper half only: ignored in the narrow layout
		push_pixel(fill_pixel(8'h80, 8'h80, 8'h80, 32'hffff_0000));
		// only bits outside the three fields: every vote is a minus
		push_pixel(fill_pixel(8'h80, 8'h80, 8'h80, wide ? 32'h0707_07ff : 32'hffff_0001));
		// half above, half below cancel out
		px = fill_pixel(8'h80, 8'h80, 8'h80, '0);
		for (int i = 0; i < NEIGHBOR_COUNT; i += 2)
			px.nbr[i] = place_fields('0, wide, '1, '1, '1);
		push_pixel(px);
		// one outcome per channel: red above, green below, blue equal
		push_pixel(fill_pixel(8'h80, 8'h80, 8'h80, place_fields('0, wide, 5'd20, 5'd10, 5'd16)));
		push_pixel(random_pixel(wide));
	endtask

	task automatic run_random(int count);
		for (int n = 0; n < count; n++)
			push_pixel(random_pixel(model.wide_format));
	endtask

	initial begin
		logic [APB_DATA_W-1:0] value;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		idle_pct = 22;
		layout_writes = 0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Narrow layout straight out of reset.
		read_format_reg();
		send_directed(1'b0);
		run_random(65);
		// Hold the sender until the pipe is empty, then resume.
		wait_drained();
		run_random(65);

		// A write to the unmapped slot must leave the layout alone.
		wait_drained();
		write_reg(REG_UNMAPPED, 32'h1);
		read_format_reg();
		run_random(70);

		// Wide layout, with junk in the unused register bits. Run a long
		// clean stretch with no idles or stalls.
		wait_drained();
		value = $urandom;
		value[0] = 1'b1;
		write_reg(drf_pkg::REG_WIDE_FORMAT, value);
		read_format_reg();
		send_directed(1'b1);
		idle_pct = 0;
		run_random(200);
		idle_pct = 22;

		// Back to narrow, then wide again.
		wait_drained();
		value = $urandom;
		value[0] = 1'b0;
		write_reg(drf_pkg::REG_WIDE_FORMAT, value);
		read_format_reg();
		run_random(170);

		wait_drained();
		value = $urandom;
		value[0] = 1'b1;
		write_reg(drf_pkg::REG_WIDE_FORMAT, value);
		read_format_reg();
		run_random(170);

		wait_drained();
		if (model.expected_q.size() != 0)
			model.flag_mismatch($sformatf("%0d restored words never arrived",
				model.expected_q.size()));
		$display("covered %0d pixels and %0d restored words over %0d layout writes",
			model.pixels_noted, model.words_checked, layout_writes);
		$display("both neighbor layouts, an unmapped write, stalls, idles and a drain pause");
		if (model.mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
